// ===== src/lnle_pkg.sv =====
`timescale 1ns / 1ps

package lnle_pkg;

	localparam int NAME_LEN = 16;
	localparam int FILL_W   = $clog2(NAME_LEN + 1);
	localparam int IDX_W    = $clog2(NAME_LEN);

	typedef logic [6:0] char_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;
	typedef logic       reg_idx_t;

	localparam kind_t KIND_ECHO = 2'd0;
	localparam kind_t KIND_CHAR = 2'd1;
	localparam kind_t KIND_END  = 2'd2;

	localparam status_t ST_NAME_DONE = 2'd0;
	localparam status_t ST_GOT_NUL   = 2'd1;
	localparam status_t ST_GOT_EOT   = 2'd2;

	localparam reg_idx_t REG_ERASE = 1'b0;
	localparam reg_idx_t REG_KILL  = 1'b1;

	localparam char_t ERASE_RESET = 7'o010;
	localparam char_t KILL_RESET  = 7'o025;
	localparam char_t CH_NUL      = 7'h00;
	localparam char_t CH_EOT      = 7'o004;
	localparam char_t CH_LF       = 7'h0A;
	localparam char_t CH_CR       = 7'h0D;
	localparam char_t CH_SPACE    = 7'h20;
	localparam char_t CH_UNDER    = 7'h5F;
	localparam char_t CH_UP_A     = 7'h41;
	localparam char_t CH_UP_Z     = 7'h5A;
	localparam char_t CH_LO_A     = 7'h61;
	localparam char_t CH_LO_Z     = 7'h7A;
	localparam char_t CASE_DELTA  = 7'h20;

endpackage

// ===== src/lnle_if.sv =====
`timescale 1ns / 1ps

interface lnle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lnle_res_if;
	logic                 valid;
	logic                 ready;
	lnle_pkg::kind_t      out_kind;
	logic [7:0]           out_byte;
	logic                 last_of_run;
	lnle_pkg::status_t    end_status;
	logic                 ended_by_cr;
	logic                 upper_seen;
	logic                 lower_seen;

	modport source (output valid, output out_kind, output out_byte, output last_of_run,
		output end_status, output ended_by_cr, output upper_seen, output lower_seen,
		input ready);
	modport sink (input valid, input out_kind, input out_byte, input last_of_run,
		input end_status, input ended_by_cr, input upper_seen, input lower_seen,
		output ready);
endinterface

// ===== src/login_name_line_editor.sv =====
`timescale 1ns / 1ps

// Login name line editor.
// rx carries raw terminal bytes (bit 7 ignored); res carries results: echo bytes with
// even parity, name characters and end records. last_of_run marks the final result of
// one input byte. cfg_we/cfg_index/cfg_data write erase_char (index 0) or kill_char
// (index 1); write only while the block is idle.
// Timing: a byte is taken in ST_IDLE and decoded in ST_DECODE. An echoed byte gives one
// result; kill gives three (its own echo, then CR and LF), one per cycle while the
// receiver takes them. At end of name each stored character is read in ST_READ, as the
// name memory read is registered, and sent in ST_EMIT; the end record follows in ST_END.
// The result sits in a single output register; while the receiver stalls, the
// sequencer waits and at most one further byte is taken and held.
// Reset empties the name, clears both case flags, restores erase (BS) and kill
// (NAK) codes and drops any pending result. Name memory needs no clearing pass:
// only entries below the fill count are read.
module login_name_line_editor (
	input  logic                   clk,
	input  logic                   arst_n,
	lnle_rx_if.sink                rx,
	lnle_res_if.source             res,
	input  logic                   cfg_we,
	input  lnle_pkg::reg_idx_t     cfg_index,
	input  lnle_pkg::char_t        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_KILL_CR,
		ST_KILL_LF,
		ST_READ,
		ST_EMIT,
		ST_END
	} state_t;

	state_t                          state_q;
	lnle_pkg::char_t                 c_q;
	lnle_pkg::char_t                 erase_q;
	lnle_pkg::char_t                 kill_q;
	logic [lnle_pkg::FILL_W-1:0]     fill_q;
	logic [lnle_pkg::IDX_W-1:0]      idx_q;
	logic                            upper_q;
	logic                            lower_q;
	logic                            cr_q;

	logic                            res_valid_q;
	lnle_pkg::kind_t                 kind_q;
	logic [7:0]                      byte_q;
	logic                            last_q;
	lnle_pkg::status_t               status_q;
	logic                            endcr_q;
	logic                            up_q;
	logic                            lo_q;

	lnle_pkg::char_t                 name_mem [lnle_pkg::NAME_LEN];
	lnle_pkg::char_t                 rd_data_q;

	logic                            slot_free;
	logic                            res_load;
	logic                            is_nul_eot;
	logic                            is_end;
	logic                            is_upper;
	logic                            is_lower;
	logic                            is_erase;
	logic                            is_kill;
	logic                            mem_we;
	lnle_pkg::char_t                 store_char;
	lnle_pkg::char_t                 name_char;
	logic                            last_idx;

	function automatic logic [7:0] with_parity(input lnle_pkg::char_t ch);
		return {^ch, ch};
	endfunction

	assign rx.ready = (state_q == ST_IDLE);

	assign res.valid       = res_valid_q;
	assign res.out_kind    = kind_q;
	assign res.out_byte    = byte_q;
	assign res.last_of_run = last_q;
	assign res.end_status  = status_q;
	assign res.ended_by_cr = endcr_q;
	assign res.upper_seen  = up_q;
	assign res.lower_seen  = lo_q;

	always_comb begin
		slot_free  = !res_valid_q || res.ready;
		is_nul_eot = (c_q == lnle_pkg::CH_NUL) || (c_q == lnle_pkg::CH_EOT);
		// full store ends the name on any further byte other than NUL or EOT
		is_end     = (c_q == lnle_pkg::CH_CR) || (c_q == lnle_pkg::CH_LF)
			|| (fill_q >= lnle_pkg::FILL_W'(lnle_pkg::NAME_LEN));
		is_lower   = (c_q >= lnle_pkg::CH_LO_A) && (c_q <= lnle_pkg::CH_LO_Z);
		is_upper   = (c_q >= lnle_pkg::CH_UP_A) && (c_q <= lnle_pkg::CH_UP_Z);
		is_erase   = !is_lower && !is_upper && (c_q == erase_q);
		is_kill    = !is_lower && !is_upper && !is_erase && (c_q == kill_q);
		store_char = (c_q == lnle_pkg::CH_SPACE) ? lnle_pkg::CH_UNDER : c_q;
		mem_we     = (state_q == ST_DECODE) && slot_free && !is_nul_eot && !is_end
			&& !is_erase && !is_kill;
		// output register gets a new result this cycle
		res_load   = slot_free && (((state_q == ST_DECODE) && (is_nul_eot || !is_end))
			|| (state_q == ST_KILL_CR) || (state_q == ST_KILL_LF)
			|| (state_q == ST_EMIT) || (state_q == ST_END));
		name_char  = rd_data_q;
		if (upper_q && !lower_q && (rd_data_q >= lnle_pkg::CH_UP_A)
				&& (rd_data_q <= lnle_pkg::CH_UP_Z)) begin
			name_char = rd_data_q + lnle_pkg::CASE_DELTA;
		end
		last_idx   = ({1'b0, idx_q} + lnle_pkg::FILL_W'(1)) == fill_q;
	end

	// Writes happen only while decoding; read data is used only while draining, so no forwarding.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			name_mem[fill_q[lnle_pkg::IDX_W-1:0]] <= store_char;
		end
		rd_data_q <= name_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			c_q         <= '0;
			erase_q     <= lnle_pkg::ERASE_RESET;
			kill_q      <= lnle_pkg::KILL_RESET;
			fill_q      <= '0;
			idx_q       <= '0;
			upper_q     <= 1'b0;
			lower_q     <= 1'b0;
			cr_q        <= 1'b0;
			res_valid_q <= 1'b0;
			kind_q      <= lnle_pkg::KIND_ECHO;
			byte_q      <= '0;
			last_q      <= 1'b0;
			status_q    <= lnle_pkg::ST_NAME_DONE;
			endcr_q     <= 1'b0;
			up_q        <= 1'b0;
			lo_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lnle_pkg::REG_ERASE: erase_q <= cfg_data;
					lnle_pkg::REG_KILL:  kill_q  <= cfg_data;
					default: ;
				endcase
			end

			if (res_valid_q && res.ready && !res_load) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (rx.valid) begin
						c_q     <= rx.rx_byte[6:0];
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (slot_free) begin
						if (is_nul_eot) begin
							res_valid_q <= 1'b1;
							kind_q      <= lnle_pkg::KIND_END;
							byte_q      <= '0;
							last_q      <= 1'b1;
							status_q    <= (c_q == lnle_pkg::CH_NUL) ? lnle_pkg::ST_GOT_NUL
								: lnle_pkg::ST_GOT_EOT;
							endcr_q     <= 1'b0;
							up_q        <= 1'b0;
							lo_q        <= 1'b0;
							fill_q      <= '0;
							upper_q     <= 1'b0;
							lower_q     <= 1'b0;
							state_q     <= ST_IDLE;
						end else if (is_end) begin
							cr_q  <= (c_q == lnle_pkg::CH_CR);
							idx_q <= '0;
							state_q <= (fill_q == '0) ? ST_END : ST_READ;
						end else begin
							res_valid_q <= 1'b1;
							kind_q      <= lnle_pkg::KIND_ECHO;
							byte_q      <= with_parity(c_q);
							last_q      <= !is_kill;
							status_q    <= lnle_pkg::ST_NAME_DONE;
							endcr_q     <= 1'b0;
							up_q        <= 1'b0;
							lo_q        <= 1'b0;
							if (is_lower) begin
								lower_q <= 1'b1;
							end
							if (is_upper) begin
								upper_q <= 1'b1;
							end
							if (is_erase) begin
								if (fill_q != '0) begin
									fill_q <= fill_q - lnle_pkg::FILL_W'(1);
								end
								state_q <= ST_IDLE;
							end else if (is_kill) begin
								fill_q  <= '0;
								state_q <= ST_KILL_CR;
							end else begin
								fill_q  <= fill_q + lnle_pkg::FILL_W'(1);
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_KILL_CR: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= lnle_pkg::KIND_ECHO;
						byte_q      <= with_parity(lnle_pkg::CH_CR);
						last_q      <= 1'b0;
						state_q     <= ST_KILL_LF;
					end
				end
				ST_KILL_LF: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= lnle_pkg::KIND_ECHO;
						byte_q      <= with_parity(lnle_pkg::CH_LF);
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_READ: begin
					// rd_data_q holds name_mem[idx_q] next cycle
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= lnle_pkg::KIND_CHAR;
						byte_q      <= {1'b0, name_char};
						last_q      <= 1'b0;
						status_q    <= lnle_pkg::ST_NAME_DONE;
						endcr_q     <= 1'b0;
						up_q        <= 1'b0;
						lo_q        <= 1'b0;
						if (last_idx) begin
							state_q <= ST_END;
						end else begin
							idx_q   <= idx_q + lnle_pkg::IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_END: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= lnle_pkg::KIND_END;
						byte_q      <= '0;
						last_q      <= 1'b1;
						status_q    <= lnle_pkg::ST_NAME_DONE;
						endcr_q     <= cr_q;
						up_q        <= upper_q;
						lo_q        <= lower_q;
						fill_q      <= '0;
						upper_q     <= 1'b0;
						lower_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
